/* design/sm4_pkg.sv */
// ----------------------------------------------------------------------------
// SM4 shared definitions
// Constant tables and round functions used by the key schedule and the
// cipher round stages.
// ----------------------------------------------------------------------------
package sm4_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BLOCK_W = 128;

    // Byte substitution table of the published standard.
    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
    localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
    localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
    localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

    // Register indexes of the configuration port.
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    // Control from the configuration port to the key schedule.
    typedef struct packed {
        logic        wr;
        logic        sel;
        logic [63:0] data;
    } t_key_wr;

    // Non-linear transform: the S-box on each byte.
    function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
        return y;
    endfunction

    // Linear map of the data rounds.
    function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] y;
        y = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
              ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
        return y;
    endfunction

    // Linear map of the key schedule.
    function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] y;
        y = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
        return y;
    endfunction

    // CK constant: byte j of word i is (4i + j) * 7 modulo 256.
    function automatic logic [WORD_W-1:0] ck_word(input logic [5:0] idx);
        logic [WORD_W-1:0] w;
        logic [7:0]        base;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            base = {idx, 2'b00} + 8'(j);
            w = {w[23:0], 8'(base * 8'd7)};
        end
        return w;
    endfunction

endpackage

/* design/sm4_key_sched.sv */
// ----------------------------------------------------------------------------
// SM4 key schedule
// Holds the key registers and expands the key into the round keys, one
// round key per cycle, after reset and after every key write.
// ----------------------------------------------------------------------------
module sm4_key_sched #(
    parameter int unsigned ROUNDS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sm4_pkg::t_key_wr            i_wr,
    output logic [63:0]                 o_key_high,
    output logic [63:0]                 o_key_low,
    output logic                        o_busy,
    output logic [ROUNDS-1:0][31:0]     o_round_keys
);
    import sm4_pkg::*;

    localparam int unsigned CNT_W = $clog2(ROUNDS);

    logic [63:0]            r_key_high;
    logic [63:0]            r_key_low;
    logic [3:0][31:0]       r_k;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic [ROUNDS-1:0][31:0] r_rk;
    logic [63:0]            n_key_high;
    logic [63:0]            n_key_low;
    logic [31:0]            n_word;

    // New key values as seen by a write in this cycle.
    always_comb begin
        n_key_high = r_key_high;
        n_key_low  = r_key_low;
        if (i_wr.wr) begin
            if (i_wr.sel == REG_KEY_HIGH) begin
                n_key_high = i_wr.data;
            end else begin
                n_key_low = i_wr.data;
            end
        end
    end

    // One key schedule round.
    assign n_word = r_k[0] ^ lin_key(tau(r_k[1] ^ r_k[2] ^ r_k[3] ^ ck_word(6'(r_cnt))));

    // Key registers, expansion state and round key store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_k        <= {FK3, FK2, FK1, FK0};
            r_cnt      <= '0;
            r_busy     <= 1'b1;
        end else if (i_wr.wr) begin
            r_key_high <= n_key_high;
            r_key_low  <= n_key_low;
            r_k[0]     <= n_key_high[63:32] ^ FK0;
            r_k[1]     <= n_key_high[31:0] ^ FK1;
            r_k[2]     <= n_key_low[63:32] ^ FK2;
            r_k[3]     <= n_key_low[31:0] ^ FK3;
            r_cnt      <= '0;
            r_busy     <= 1'b1;
        end else if (r_busy) begin
            r_rk[r_cnt] <= n_word;
            r_k         <= {n_word, r_k[3], r_k[2], r_k[1]};
            r_cnt       <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ROUNDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_key_high   = r_key_high;
    assign o_key_low    = r_key_low;
    assign o_busy       = r_busy;
    assign o_round_keys = r_rk;

endmodule

/* design/sm4_round_stage.sv */
// ----------------------------------------------------------------------------
// SM4 round stage
// One cipher round followed by a pipeline register, with the valid bit and
// direction travelling alongside the state.
// ----------------------------------------------------------------------------
module sm4_round_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic                        i_act,
    input  logic [sm4_pkg::BLOCK_W-1:0] i_state,
    input  logic [31:0]                 i_rk_enc,
    input  logic [31:0]                 i_rk_dec,
    output logic                        o_valid,
    output logic                        o_act,
    output logic [sm4_pkg::BLOCK_W-1:0] o_state
);
    import sm4_pkg::*;

    logic                 r_valid;
    logic                 r_act;
    logic [BLOCK_W-1:0]   r_state;
    logic [31:0]          rk;
    logic [31:0]          n_word;

    // Round key by direction, then one round; word 0 sits at the top.
    assign rk     = i_act ? i_rk_dec : i_rk_enc;
    assign n_word = i_state[127:96]
                  ^ lin_data(tau(i_state[95:64] ^ i_state[63:32] ^ i_state[31:0] ^ rk));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act   <= i_act;
            r_state <= {i_state[95:0], n_word};
        end
    end

    assign o_valid = r_valid;
    assign o_act   = r_act;
    assign o_state = r_state;

endmodule

/* design/sm4_block_cipher.sv */
// Each accepted request passes through the round stages, one round per stage.
// Throughput: one block per cycle while o_in_stall is low; the 32-stage round pipeline sets this figure.
// After reset and after each key write the key schedule computes the round keys,
// one round key per cycle, while o_in_stall is held high.
// Reset is synchronous and active low; it clears valid bits and the key to zero.
// ----------------------------------------------------------------------------
// SM4 block cipher top level
// Fully unrolled ECB pipeline with an APB key port and a sequential key
// schedule.
// ----------------------------------------------------------------------------
module sm4_block_cipher #(
    parameter int unsigned ROUNDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);
    import sm4_pkg::*;

    t_key_wr                 key_wr;
    logic [63:0]             key_high;
    logic [63:0]             key_low;
    logic                    key_busy;
    logic [ROUNDS-1:0][31:0] round_keys;
    logic                    adv;
    logic [ROUNDS:0]         st_valid;
    logic [ROUNDS:0]         st_act;
    logic [ROUNDS:0][BLOCK_W-1:0] st_state;
    logic [BLOCK_W-1:0]      fin;

    // Configuration port.
    assign pready      = 1'b1;
    assign key_wr.wr   = psel && penable && pwrite;
    assign key_wr.sel  = paddr[3];
    assign key_wr.data = pwdata;
    assign prdata      = (paddr[3] == REG_KEY_LOW) ? key_low : key_high;

    sm4_key_sched #(.ROUNDS(ROUNDS)) u_key (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (key_wr),
        .o_key_high   (key_high),
        .o_key_low    (key_low),
        .o_busy       (key_busy),
        .o_round_keys (round_keys)
    );

    // Pipeline advances unless a finished result is held by the consumer.
    assign adv        = !(st_valid[ROUNDS] && i_out_stall);
    assign o_in_stall = key_busy || !adv;

    assign st_valid[0] = i_in_valid && !key_busy;
    assign st_act[0]   = i_action;
    assign st_state[0] = {i_block_high, i_block_low};

    // Unrolled round stages.
    for (genvar s = 0; s < ROUNDS; s++) begin : g_round
        sm4_round_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (adv),
            .i_valid  (st_valid[s]),
            .i_act    (st_act[s]),
            .i_state  (st_state[s]),
            .i_rk_enc (round_keys[s]),
            .i_rk_dec (round_keys[ROUNDS-1-s]),
            .o_valid  (st_valid[s+1]),
            .o_act    (st_act[s+1]),
            .o_state  (st_state[s+1])
        );
    end

    // Result words leave in reverse order.
    assign fin           = st_state[ROUNDS];
    assign o_out_valid   = st_valid[ROUNDS];
    assign o_result_high = {fin[31:0], fin[63:32]};
    assign o_result_low  = {fin[95:64], fin[127:96]};

endmodule

/* design/sm4_checker.sv */
// ----------------------------------------------------------------------------
// SM4 port checker
// Watches the top level ports for reset, stall and key port behaviour.
// ----------------------------------------------------------------------------
module sm4_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_result_high,
    input logic [63:0] o_result_low
);

    // No result is shown in the cycle after reset.
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A held result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_high)
            && $stable(o_result_low))
        else $error("held result changed");

    // A blocked output blocks the input side too.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output blocked");

    // A key write starts the schedule, which holds off new requests.
    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |=> o_in_stall)
        else $error("request taken during key expansion");

    // The key port never waits.
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind sm4_block_cipher sm4_checker u_sm4_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_high (o_result_high),
    .o_result_low  (o_result_low)
);
